// ----- rtl/sm4_pkg.sv -----
// ----------------------------------------------------------------------------
// sm4 package
// shared types, constants and round functions of the sm4 cipher engine
// ----------------------------------------------------------------------------
package sm4_pkg;

  localparam int unsigned BlockW = 64;
  localparam int unsigned CntW   = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW   = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKeyHigh  = 3'd0,
    CfgKeyLow   = 3'd1,
    CfgIvHigh   = 3'd2,
    CfgIvLow    = 3'd3,
    CfgChain    = 3'd4,
    CfgDir      = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [BlockW-1:0] block_high;
    logic [BlockW-1:0] block_low;
    logic [CntW-1:0]   byte_count;
    logic              last_block;
  } in_item_t;

  typedef struct packed {
    logic [BlockW-1:0] result_high;
    logic [BlockW-1:0] result_low;
    logic [CntW-1:0]   valid_bytes;
    logic              end_of_message;
    logic              pad_error;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic key_init;   // load key words xor fk
    logic key_step;   // one key schedule round
    logic blk_load;   // load block from input (with pad / chain)
    logic pad_load;   // load the extra all-pad block
    logic rnd_step;   // one cipher round
    logic finish;     // compute result, update chain
  } dp_cmd_t;

  localparam logic [31:0] Fk [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

  localparam logic [7:0] Sbox [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // key schedule constant: byte j of ck[i] is (4*i+j)*7 mod 256
  function automatic logic [31:0] ck_word(input logic [4:0] i);
    logic [7:0] b0;
    b0 = {i, 2'b00} * 8'd7;
    return {b0, b0 + 8'd7, b0 + 8'd14, b0 + 8'd21};
  endfunction

  function automatic logic [31:0] subst(input logic [31:0] x);
    return {Sbox[x[31:24]], Sbox[x[23:16]], Sbox[x[15:8]], Sbox[x[7:0]]};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] round_mix(input logic [31:0] x);
    logic [31:0] t;
    t = subst(x);
    return t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
  endfunction

  function automatic logic [31:0] key_mix(input logic [31:0] x);
    logic [31:0] t;
    t = subst(x);
    return t ^ rotl(t, 13) ^ rotl(t, 23);
  endfunction

endpackage

// ----- rtl/sm4_stream_if.sv -----
// ----------------------------------------------------------------------------
// sm4 stream interface
// valid/ready channel carrying one payload item per transaction
// ----------------------------------------------------------------------------
interface sm4_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/sm4_datapath.sv -----
// ----------------------------------------------------------------------------
// sm4 datapath
// round key store, shared round unit, padding, chaining and result register
// ----------------------------------------------------------------------------
module sm4_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sm4_pkg::dp_cmd_t   cmd_i,
  input  logic [4:0]         round_i,
  input  logic               msg_start_i,
  input  logic               chain_mode_i,
  input  logic               direction_i,
  input  logic [127:0]       key_i,
  input  logic [127:0]       iv_i,
  input  sm4_pkg::in_item_t  item_i,
  input  logic               eom_i,
  output sm4_pkg::out_item_t result_o
);
  import sm4_pkg::*;

  logic [31:0]  rk_mem [32];
  logic [31:0]  rk_q;
  logic [127:0] kw_q, kw_d;
  logic [127:0] x_q, x_d;
  logic [127:0] chain_q, chain_d;
  logic [127:0] cin_q;
  logic [127:0] blk_in;
  logic [127:0] padded;
  logic [4:0]   n_eff;
  logic         pad_hi_err;
  logic [31:0]  nk;
  logic [31:0]  nx;
  logic [127:0] plain;
  logic [127:0] ciph_out;
  logic [4:0]   rd_addr;
  logic [7:0]   pval;
  out_item_t    res_d, res_q;

  assign blk_in = {item_i.block_high, item_i.block_low};

  // padding of the final partial block
  always_comb begin
    n_eff = (item_i.byte_count > 5'd16 || !item_i.last_block) ? 5'd16 : item_i.byte_count;
    for (int b = 0; b < 16; b++) begin
      padded[127-8*b -: 8] = (5'(b) < n_eff) ?
        blk_in[127-8*b -: 8] : 8'(5'd16 - n_eff);
    end
  end

  // key schedule round and cipher round share the sbox style of logic
  assign nk = kw_q[127:96] ^ key_mix(kw_q[95:64] ^ kw_q[63:32] ^ kw_q[31:0] ^ ck_word(round_i));
  assign nx = x_q[127:96] ^ round_mix(x_q[95:64] ^ x_q[63:32] ^ x_q[31:0] ^ rk_q);

  assign ciph_out = {x_q[31:0], x_q[63:32], x_q[95:64], x_q[127:96]};

  always_comb begin
    kw_d = kw_q;
    if (cmd_i.key_init) begin
      kw_d = key_i ^ {Fk[0], Fk[1], Fk[2], Fk[3]};
    end else if (cmd_i.key_step) begin
      kw_d = {kw_q[95:0], nk};
    end
  end

  // chain value used by the current block
  logic [127:0] chain_use;
  assign chain_use = msg_start_i ? iv_i : chain_q;

  always_comb begin
    x_d = x_q;
    if (cmd_i.blk_load) begin
      if (direction_i) x_d = blk_in;
      else x_d = padded ^ (chain_mode_i ? chain_use : '0);
    end else if (cmd_i.pad_load) begin
      // extra pad block chains on the ciphertext finished in this cycle
      x_d = {16{8'h10}} ^ (chain_mode_i ? ciph_out : '0);
    end else if (cmd_i.rnd_step) begin
      x_d = {x_q[95:0], nx};
    end
  end

  // result and chaining update
  assign plain = ciph_out ^ (chain_mode_i ? cin_q : '0);
  assign pval = plain[7:0];
  assign pad_hi_err = (pval == 8'd0) || (pval > 8'd16);

  always_comb begin
    chain_d = chain_q;
    res_d = res_q;
    if (cmd_i.blk_load) begin
      chain_d = chain_use;
    end
    if (cmd_i.finish) begin
      if (direction_i) begin
        chain_d = cin_q;
        res_d.result_high = plain[127:64];
        res_d.result_low = plain[63:0];
        res_d.valid_bytes = (eom_i && !pad_hi_err) ? 5'(8'd16 - pval) : 5'd16;
        res_d.pad_error = eom_i && pad_hi_err;
      end else begin
        chain_d = ciph_out;
        res_d.result_high = ciph_out[127:64];
        res_d.result_low = ciph_out[63:0];
        res_d.valid_bytes = 5'd16;
        res_d.pad_error = 1'b0;
      end
      res_d.end_of_message = eom_i;
    end
  end

  // decrypt chaining input: ciphertext for next, previous chain for xor
  logic [127:0] cin_d;
  always_comb begin
    cin_d = cin_q;
    if (cmd_i.blk_load) begin
      cin_d = direction_i ? chain_use : '0;
    end
    if (cmd_i.finish && direction_i) begin
      cin_d = cin_q;
    end
  end

  // decrypt stores the ciphertext separately for the next chain value
  logic [127:0] ct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= '0;
    end else begin
      if (cmd_i.finish && direction_i) chain_q <= ct_q;
      else chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kw_q <= kw_d;
    x_q <= x_d;
    cin_q <= cin_d;
    res_q <= res_d;
    if (cmd_i.blk_load) ct_q <= blk_in;
  end

  // round key store; the key read is registered, so the address leads its round
  assign rd_addr = direction_i ? ~round_i : round_i;
  always_ff @(posedge clk_i) begin
    if (cmd_i.key_step) rk_mem[round_i] <= nk;
    rk_q <= rk_mem[rd_addr];
  end

  assign result_o = res_q;

endmodule

// ----- rtl/sm4_ctrl.sv -----
// ----------------------------------------------------------------------------
// sm4 controller
// sequences key expansion, cipher rounds and the extra padding block
// ----------------------------------------------------------------------------
module sm4_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             in_last_i,
  input  logic [4:0]       in_count_i,
  input  logic             direction_i,
  input  logic             key_write_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sm4_pkg::dp_cmd_t cmd_o,
  output logic [4:0]       round_o,
  output logic             msg_start_o,
  output logic             eom_o
);
  import sm4_pkg::*;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StKey   = 6'b000010,
    StLoad  = 6'b000100,
    StRound = 6'b001000,
    StFin   = 6'b010000,
    StOut   = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] rnd_q, rnd_d;
  logic       keys_ok_q, keys_ok_d;
  logic       start_q, start_d;
  logic       last_q, last_d;
  logic       extra_q, extra_d;
  logic       ovalid_q, ovalid_d;
  logic       in_fire;

  // a new block may be taken while the previous result waits, as long as
  // the result register is free by the time it is rewritten
  assign in_ready_o = (state_q == StIdle) && keys_ok_q;
  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    rnd_d = rnd_q;
    keys_ok_d = keys_ok_q && !key_write_i;
    start_d = start_q;
    last_d = last_q;
    extra_d = extra_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o = '0;
    eom_o = last_q && !extra_q;
    unique case (state_q)
      StIdle: begin
        if (!keys_ok_q) begin
          // expand round keys before the waiting block is taken
          if (in_valid_i) begin
            cmd_o.key_init = 1'b1;
            rnd_d = '0;
            state_d = StKey;
          end
        end else if (in_fire) begin
          last_d = in_last_i;
          extra_d = in_last_i && !direction_i && (in_count_i >= 5'd16);
          rnd_d = '0;
          cmd_o.blk_load = 1'b1;
          state_d = StLoad;
        end
      end
      StKey: begin
        cmd_o.key_step = 1'b1;
        rnd_d = rnd_q + 5'd1;
        if (rnd_q == 5'd31) begin
          keys_ok_d = 1'b1;
          state_d = StIdle;
        end
      end
      StLoad: begin
        // key read for round 0 is in flight
        start_d = 1'b0;
        rnd_d = 5'd1;
        state_d = StRound;
      end
      StRound: begin
        cmd_o.rnd_step = 1'b1;
        rnd_d = rnd_q + 5'd1;
        if (rnd_q == 5'd0) state_d = StFin;
      end
      StFin: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          ovalid_d = 1'b1;
          if (extra_q) begin
            extra_d = 1'b0;
            cmd_o.pad_load = 1'b1;
            rnd_d = '0;
            state_d = StOut;
          end else begin
            if (last_q) start_d = 1'b1;
            state_d = StIdle;
          end
        end
      end
      StOut: begin
        // pad block loaded, prime key read like the load state
        rnd_d = 5'd1;
        state_d = StRound;
      end
      default: state_d = StIdle;
    endcase
  end

  // round index drives key address; during load it points at round 0
  assign round_o = (state_q == StIdle || state_q == StFin) ? 5'd0 : rnd_q;
  assign msg_start_o = start_q;
  assign out_valid_o = ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rnd_q <= '0;
      keys_ok_q <= 1'b0;
      start_q <= 1'b1;
      last_q <= 1'b0;
      extra_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rnd_q <= rnd_d;
      keys_ok_q <= keys_ok_d;
      start_q <= start_d;
      last_q <= last_d;
      extra_q <= extra_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

// ----- rtl/sm4_block_cipher_ecb_cbc_unit.sv -----
// ----------------------------------------------------------------------------
// sm4 block cipher ecb/cbc unit
// sm4 engine with pkcs7 style padding and pad removal
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one 128-bit block per transaction with a byte count and a
//   last flag; out_if returns result blocks. Configuration registers (key,
//   iv, chain mode, direction) are written through cfg_we_i / cfg_idx_i /
//   cfg_wdata_i; the user must write them only while the unit is idle, as
//   the unit does not enforce this. After a key write, a waiting block
//   first triggers the 32-step key schedule on the shared key round logic
//   and is accepted after. Each block then runs a load step, 32 cipher
//   rounds on one round unit and a finish step; a new block is accepted
//   only after the round loop is done. A full final encrypt block yields a
//   second padding block, run through the rounds after the first result.
//   The result register holds a result until taken; a stalled receiver
//   holds the unit in its finish step, and the next block is accepted once
//   the unit is back to idle.
//   Reset clears control state, marks keys as not expanded and starts a
//   new message; the round key store has no reset.
// ----------------------------------------------------------------------------
module sm4_block_cipher_ecb_cbc_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sm4_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sm4_pkg::CfgW-1:0]    cfg_wdata_i,
  sm4_stream_if.sink                  in_if,
  sm4_stream_if.source                out_if
);
  import sm4_pkg::*;

  logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic        chain_q, dir_q;
  logic        key_write;
  dp_cmd_t     cmd;
  logic [4:0]  round;
  logic        msg_start;
  logic        eom;
  in_item_t    item;

  assign item = in_if.payload;
  assign key_write = cfg_we_i &&
    (cfg_idx_i == CfgKeyHigh || cfg_idx_i == CfgKeyLow);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      iv_hi_q <= '0;
      iv_lo_q <= '0;
      chain_q <= 1'b0;
      dir_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgKeyHigh: key_hi_q <= cfg_wdata_i;
        CfgKeyLow:  key_lo_q <= cfg_wdata_i;
        CfgIvHigh:  iv_hi_q <= cfg_wdata_i;
        CfgIvLow:   iv_lo_q <= cfg_wdata_i;
        CfgChain:   chain_q <= cfg_wdata_i[0];
        CfgDir:     dir_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  sm4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .in_last_i   (item.last_block),
    .in_count_i  (item.byte_count),
    .direction_i (dir_q),
    .key_write_i (key_write),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd),
    .round_o     (round),
    .msg_start_o (msg_start),
    .eom_o       (eom)
  );

  sm4_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .round_i      (round),
    .msg_start_i  (msg_start),
    .chain_mode_i (chain_q),
    .direction_i  (dir_q),
    .key_i        ({key_hi_q, key_lo_q}),
    .iv_i         ({iv_hi_q, iv_lo_q}),
    .item_i       (item),
    .eom_i        (eom),
    .result_o     (out_if.payload)
  );

  // assertions
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.rnd_step || cmd.key_step) |-> !in_if.ready)
    else $error("input accepted while rounds run");
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.key_step, cmd.rnd_step, cmd.finish}))
    else $error("conflicting datapath commands");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> out_if.valid)
    else $error("result dropped under stall");

endmodule

// ----- tb/sv/sm4_block_cipher_ecb_cbc_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sm4 block cipher ecb/cbc unit testbench
// drives blocks through the stream interfaces under random idling, predicts
// every result with an independent sm4 model and compares field by field
// ----------------------------------------------------------------------------
module sm4_block_cipher_ecb_cbc_unit_tb;
  import sm4_pkg::*;

  localparam logic [31:0] FkW [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};
  localparam logic [63:0] PadFull = 64'h1010101010101010;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_wdata_i;

  sm4_stream_if #(.payload_t(in_item_t)) in_if ();
  sm4_stream_if #(.payload_t(out_item_t)) out_if ();

  sm4_block_cipher_ecb_cbc_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  // predictor state and configuration copy
  logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic        cbc_q, decrypt_q;
  logic [31:0] rk_q [32];
  logic        rk_valid_q;
  logic [63:0] chain_hi_q, chain_lo_q;
  logic        msg_first_q;
  logic        in_taken;

  in_item_t  block_queue [$];
  out_item_t result_queue [$];
  int        send_idle_pct, recv_stall_pct;
  bit        failed;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // timeout
  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [31:0] sbox_word(logic [31:0] x);
    logic [31:0] r;
    for (int b = 0; b < 4; b++) r[b*8 +: 8] = Sbox[x[b*8 +: 8]];
    return r;
  endfunction

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // round key schedule
  task automatic expand_round_keys();
    logic [31:0] k [4];
    logic [31:0] t, nk;
    logic [7:0]  c0;
    k[0] = key_hi_q[63:32] ^ FkW[0];
    k[1] = key_hi_q[31:0] ^ FkW[1];
    k[2] = key_lo_q[63:32] ^ FkW[2];
    k[3] = key_lo_q[31:0] ^ FkW[3];
    for (int i = 0; i < 32; i++) begin
      c0 = 8'(i * 28);
      t = sbox_word(k[1] ^ k[2] ^ k[3] ^ {c0, c0 + 8'd7, c0 + 8'd14, c0 + 8'd21});
      nk = k[0] ^ t ^ rol(t, 13) ^ rol(t, 23);
      rk_q[i] = nk;
      k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = nk;
    end
    rk_valid_q = 1'b1;
  endtask

  function automatic logic [127:0] sm4_crypt(logic [127:0] blk, logic inv);
    logic [31:0] x [4];
    logic [31:0] t, nx;
    for (int i = 0; i < 4; i++) x[i] = blk[127 - 32*i -: 32];
    for (int i = 0; i < 32; i++) begin
      t = sbox_word(x[1] ^ x[2] ^ x[3] ^ (inv ? rk_q[31 - i] : rk_q[i]));
      nx = x[0] ^ t ^ rol(t, 2) ^ rol(t, 10) ^ rol(t, 18) ^ rol(t, 24);
      x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nx;
    end
    return {x[3], x[2], x[1], x[0]};
  endfunction

  task automatic encrypt_link(inout logic [127:0] blk);
    if (cbc_q) blk = blk ^ {chain_hi_q, chain_lo_q};
    blk = sm4_crypt(blk, 1'b0);
    {chain_hi_q, chain_lo_q} = blk;
  endtask

  // expected results of one accepted block
  task automatic predict_block(in_item_t it);
    logic [127:0] blk, ct;
    out_item_t r;
    int n;
    logic [7:0] pad;
    blk = {it.block_high, it.block_low};
    n = it.byte_count;
    if (!rk_valid_q) expand_round_keys();
    if (msg_first_q) begin
      chain_hi_q = iv_hi_q; chain_lo_q = iv_lo_q; msg_first_q = 1'b0;
    end
    if (n > 16 || !it.last_block) n = 16;
    r.pad_error = 1'b0;
    r.valid_bytes = 5'd16;
    if (!decrypt_q) begin
      for (int b = n; b < 16; b++) blk[127 - 8*b -: 8] = 8'(16 - n);
      encrypt_link(blk);
      {r.result_high, r.result_low} = blk;
      r.end_of_message = it.last_block && n < 16;
      result_queue.push_back(r);
      if (it.last_block && n == 16) begin
        blk = {PadFull, PadFull};
        encrypt_link(blk);
        {r.result_high, r.result_low} = blk;
        r.end_of_message = 1'b1;
        result_queue.push_back(r);
      end
    end else begin
      ct = blk;
      blk = sm4_crypt(blk, 1'b1);
      if (cbc_q) blk = blk ^ {chain_hi_q, chain_lo_q};
      {chain_hi_q, chain_lo_q} = ct;
      if (it.last_block) begin
        pad = blk[7:0];
        if (pad == 0 || pad > 16) r.pad_error = 1'b1;
        else r.valid_bytes = 5'(16 - pad);
      end
      {r.result_high, r.result_low} = blk;
      r.end_of_message = it.last_block;
      result_queue.push_back(r);
    end
    if (it.last_block) msg_first_q = 1'b1;
  endtask

  // input driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.payload <= '0;
    end else if (!in_if.valid || in_taken) begin
      if (block_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_if.valid <= 1'b1;
        in_if.payload <= block_queue.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // in_if.valid/ready settle before the edge; the flag tells the driver
  // whether its item was taken
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_if.valid && in_if.ready;
  end

  // receiver ready with random stalls
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // accepted input transaction feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) predict_block(in_if.payload);
  end

  // output monitor
  always @(posedge clk_i) begin
    out_item_t e, a;
    if (rst_ni && out_if.valid && out_if.ready) begin
      a = out_if.payload;
      if (result_queue.size() == 0) begin
        $error("unexpected result transaction %h", a);
        failed = 1'b1;
      end else begin
        e = result_queue.pop_front();
        if (a.result_high !== e.result_high) begin
          $error("result_high exp %h got %h", e.result_high, a.result_high); failed = 1'b1;
        end
        if (a.result_low !== e.result_low) begin
          $error("result_low exp %h got %h", e.result_low, a.result_low); failed = 1'b1;
        end
        if (a.valid_bytes !== e.valid_bytes) begin
          $error("valid_bytes exp %0d got %0d", e.valid_bytes, a.valid_bytes); failed = 1'b1;
        end
        if (a.end_of_message !== e.end_of_message) begin
          $error("end_of_message exp %b got %b", e.end_of_message, a.end_of_message);
          failed = 1'b1;
        end
        if (a.pad_error !== e.pad_error) begin
          $error("pad_error exp %b got %b", e.pad_error, a.pad_error); failed = 1'b1;
        end
      end
    end
  end

  // register write, mirrored in the predictor
  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgKeyHigh: begin key_hi_q = val; rk_valid_q = 1'b0; end
      CfgKeyLow:  begin key_lo_q = val; rk_valid_q = 1'b0; end
      CfgIvHigh:  iv_hi_q = val;
      CfgIvLow:   iv_lo_q = val;
      CfgChain:   cbc_q = val[0];
      CfgDir:     decrypt_q = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until everything sent has come back and the unit is quiet
  task automatic drain();
    while (block_queue.size() != 0 || in_if.valid || result_queue.size() != 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t mk_block(int cnt, bit last);
    in_item_t it;
    it.block_high = rand64();
    it.block_low = rand64();
    it.byte_count = 5'(cnt);
    it.last_block = last;
    return it;
  endfunction

  // random messages: mostly legal counts, some oversized or odd ones
  task automatic queue_messages(int blocks);
    int len, cnt;
    in_item_t it;
    while (blocks > 0) begin
      len = $urandom_range(4, 1);
      for (int b = 0; b < len; b++) begin
        cnt = ($urandom_range(9) == 0) ? $urandom_range(31) :
              (b == len - 1) ? $urandom_range(16) : 16;
        it = mk_block(cnt, b == len - 1);
        // decrypt tail often carries a legal pad byte
        if (decrypt_q && b == len - 1 && $urandom_range(3) != 0)
          it.block_low[7:0] = 8'($urandom_range(16, 1));
        block_queue.push_back(it);
        blocks--;
      end
    end
  endtask

  task automatic set_idling(int ph);
    case (ph % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
      default: begin send_idle_pct = 15; recv_stall_pct = 15; end
    endcase
  endtask

  // stimulus
  initial begin
    in_item_t it;
    failed = 1'b0;
    key_hi_q = '0; key_lo_q = '0; iv_hi_q = '0; iv_lo_q = '0;
    cbc_q = 1'b0; decrypt_q = 1'b0; rk_valid_q = 1'b0;
    chain_hi_q = '0; chain_lo_q = '0; msg_first_q = 1'b1;
    send_idle_pct = 0; recv_stall_pct = 0;
    cfg_we_i = 1'b0; cfg_idx_i = CfgKeyHigh; cfg_wdata_i = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset key, ecb encrypt, byte counts 0, 4, 8, 12, 15, 16 and 31 on last blocks
    it = mk_block(16, 1'b0);
    it.block_high = '0;
    it.block_low = '0;
    block_queue.push_back(it);
    it = mk_block(16, 1'b1);
    it.block_high = '1;
    it.block_low = '1;
    block_queue.push_back(it);
    for (int n = 0; n <= 16; n += 4) block_queue.push_back(mk_block(n, 1'b1));
    block_queue.push_back(mk_block(5'd31, 1'b1));
    block_queue.push_back(mk_block(3, 1'b0));
    block_queue.push_back(mk_block(15, 1'b1));
    drain();

    // directed: all-ones key, cbc decrypt with pad edge cases
    write_reg(CfgKeyHigh, '1);
    write_reg(CfgKeyLow, '1);
    write_reg(CfgIvHigh, '1);
    write_reg(CfgIvLow, rand64());
    write_reg(CfgChain, 64'd1);
    write_reg(CfgDir, 64'd1);
    for (int p = 0; p < 5; p++) begin
      it = mk_block(p, 1'b1);
      it.block_low[7:0] = (p == 0) ? 8'd0 : (p == 1) ? 8'd1 : (p == 2) ? 8'd16 :
                          (p == 3) ? 8'd17 : 8'hff;
      block_queue.push_back(mk_block(0, 1'b0));
      block_queue.push_back(it);
    end
    drain();

    // random phases over several configurations
    for (int ph = 0; ph < 16; ph++) begin
      set_idling(ph);
      if (ph % 3 == 0) begin
        write_reg(CfgKeyHigh, (ph == 3) ? 64'd0 : rand64());
        write_reg(CfgKeyLow, (ph == 3) ? 64'd0 : rand64());
      end
      write_reg(CfgIvHigh, rand64());
      write_reg(CfgIvLow, (ph == 6) ? '1 : rand64());
      write_reg(CfgChain, 64'(ph % 2));
      write_reg(CfgDir, 64'((ph / 2) % 2));
      queue_messages(38);
      drain();
    end

    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
